/* rtl/tbf_pkg.sv */
// shared types, constants and address helper for the tile reflect border fill block
// no dependencies; every other file of the block but tbf_ram refers to this package by scoped names
package tbf_pkg;

    localparam int TILE_MAX_WIDTH  = 64;
    localparam int TILE_MAX_HEIGHT = 64;
    localparam int PIXEL_BITS      = 8;
    localparam int OFFSET          = 1;

    localparam int MEM_DEPTH  = TILE_MAX_WIDTH * TILE_MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int COL_SHIFT  = $clog2(TILE_MAX_WIDTH);

    // signed coordinate, covers clamped limits up to 254 and small negatives
    localparam int COORD_W    = 10;
    localparam int SUM_W      = COORD_W + COL_SHIFT + 1;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_BLOCK_WIDTH  = 3'd0,
        REG_BLOCK_HEIGHT = 3'd1,
        REG_VALID_LEFT   = 3'd2,
        REG_VALID_TOP    = 3'd3,
        REG_VALID_RIGHT  = 3'd4,
        REG_VALID_BOTTOM = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SETUP,
        ST_CHECK,
        ST_FILL_RD,
        ST_FILL_WR
    } state_t;

    typedef enum logic [1:0] {
        PH_LEFT   = 2'd0,
        PH_RIGHT  = 2'd1,
        PH_TOP    = 2'd2,
        PH_BOTTOM = 2'd3
    } phase_t;

    typedef struct packed {
        logic [6:0] block_width;
        logic [6:0] block_height;
        logic [5:0] valid_left;
        logic [5:0] valid_top;
        logic [6:0] valid_right;
        logic [6:0] valid_bottom;
    } cfg_regs_t;

    // controller to datapath
    typedef struct packed {
        logic px_wr;
        logic px_rd;
        logic setup;
        logic next_phase;
        logic step;
        logic fill_rd;
        logic fill_wr;
        logic out_load;
        logic out_from_ram;
        logic out_done;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
        logic phase_skip;
        logic last_copy;
        logic last_phase;
    } dp_status_t;

    // flat tile address, wraps modulo the memory size like two's complement
    function automatic logic [ADDR_W-1:0] flat_addr(input coord_t r, input coord_t c);
        logic signed [SUM_W-1:0] sum;
        sum = (SUM_W'(r) <<< COL_SHIFT) + SUM_W'(c);
        return sum[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/tbf_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module tbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tbf_ctrl.sv */
// controller state machine for the tile reflect border fill block
// depends on tbf_pkg; drives the datapath through dp_cmd_t and watches dp_status_t
module tbf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          item_cmd,
    input  tbf_pkg::dp_status_t status,
    output logic                in_stall,
    output tbf_pkg::dp_cmd_t    dp_cmd
);

    tbf_pkg::state_t state_reg;
    tbf_pkg::state_t state_next;
    tbf_pkg::cmd_t   cmd_code;
    logic            idle;
    logic            accept;

    assign cmd_code = tbf_pkg::cmd_t'(item_cmd);
    assign idle     = (state_reg == tbf_pkg::ST_IDLE);
    assign accept   = in_valid && idle && !status.out_busy;
    assign in_stall = !idle || status.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_code)
                        tbf_pkg::CMD_FILL: state_next = tbf_pkg::ST_SETUP;
                        tbf_pkg::CMD_READ: state_next = tbf_pkg::ST_RD_WAIT;
                        default:           state_next = tbf_pkg::ST_IDLE;
                    endcase
                end
            end
            tbf_pkg::ST_RD_WAIT: state_next = tbf_pkg::ST_IDLE;
            tbf_pkg::ST_SETUP:   state_next = tbf_pkg::ST_CHECK;
            tbf_pkg::ST_CHECK:
            begin
                if (!status.phase_skip)
                begin
                    state_next = tbf_pkg::ST_FILL_RD;
                end
                else if (status.last_phase)
                begin
                    state_next = tbf_pkg::ST_IDLE;
                end
            end
            tbf_pkg::ST_FILL_RD: state_next = tbf_pkg::ST_FILL_WR;
            tbf_pkg::ST_FILL_WR:
            begin
                if (!status.last_copy)
                begin
                    state_next = tbf_pkg::ST_FILL_RD;
                end
                else if (status.last_phase)
                begin
                    state_next = tbf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tbf_pkg::ST_CHECK;
                end
            end
            default: state_next = tbf_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        dp_cmd = '0;
        case (state_reg)
            tbf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_code)
                        tbf_pkg::CMD_WRITE:
                        begin
                            dp_cmd.px_wr    = 1'b1;
                            dp_cmd.out_load = 1'b1;
                        end
                        tbf_pkg::CMD_READ:
                        begin
                            dp_cmd.px_rd = 1'b1;
                        end
                        tbf_pkg::CMD_FILL:
                        begin
                            // limits are latched in the setup state
                        end
                        default:
                        begin
                            dp_cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            tbf_pkg::ST_RD_WAIT:
            begin
                dp_cmd.out_load     = 1'b1;
                dp_cmd.out_from_ram = 1'b1;
            end
            tbf_pkg::ST_SETUP:
            begin
                dp_cmd.setup = 1'b1;
            end
            tbf_pkg::ST_CHECK:
            begin
                if (status.phase_skip)
                begin
                    if (status.last_phase)
                    begin
                        dp_cmd.out_load = 1'b1;
                        dp_cmd.out_done = 1'b1;
                    end
                    else
                    begin
                        dp_cmd.next_phase = 1'b1;
                    end
                end
            end
            tbf_pkg::ST_FILL_RD:
            begin
                dp_cmd.fill_rd = 1'b1;
            end
            tbf_pkg::ST_FILL_WR:
            begin
                dp_cmd.fill_wr = 1'b1;
                if (!status.last_copy)
                begin
                    dp_cmd.step = 1'b1;
                end
                else if (status.last_phase)
                begin
                    dp_cmd.out_load = 1'b1;
                    dp_cmd.out_done = 1'b1;
                end
                else
                begin
                    dp_cmd.next_phase = 1'b1;
                end
            end
            default:
            begin
                dp_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/tbf_datapath.sv */
// datapath: tile ram, fill loop counters, address generation and result register
// depends on tbf_pkg and tbf_ram; steered by tbf_ctrl
module tbf_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tbf_pkg::cfg_regs_t  cfg,
    input  tbf_pkg::dp_cmd_t    dp_cmd,
    input  logic [5:0]          col,
    input  logic [5:0]          row,
    input  logic [7:0]          pixel_in,
    input  logic                out_stall,
    output tbf_pkg::dp_status_t status,
    output logic                out_valid,
    output logic [7:0]          pixel_out,
    output logic                fill_done
);

    localparam tbf_pkg::coord_t ZERO = tbf_pkg::COORD_W'(0);
    localparam tbf_pkg::coord_t ONE  = tbf_pkg::COORD_W'(1);
    localparam tbf_pkg::coord_t OFS  = tbf_pkg::COORD_W'(tbf_pkg::OFFSET);

    tbf_pkg::coord_t w_s, h_s, l_s, t_s, r_s, b_s;
    tbf_pkg::coord_t w_lim, h_lim;
    tbf_pkg::coord_t w_lim_reg, h_lim_reg;
    tbf_pkg::coord_t o_reg, o_next, i_reg, i_next;
    tbf_pkg::coord_t o_init, i_init, i_restart;
    tbf_pkg::coord_t dst_r, dst_c, src_r, src_c;
    tbf_pkg::coord_t px_r, px_c;
    tbf_pkg::phase_t phase_reg, phase_next, phase_load;
    logic            inner_last, outer_last;
    logic            phase_skip;

    logic [tbf_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [tbf_pkg::PIXEL_BITS-1:0] ram_wdata, ram_rdata;
    logic                           ram_we;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] pixel_out_reg, pixel_out_next;
    logic       fill_done_reg, fill_done_next;

    assign w_s = tbf_pkg::COORD_W'(cfg.block_width);
    assign h_s = tbf_pkg::COORD_W'(cfg.block_height);
    assign l_s = tbf_pkg::COORD_W'(cfg.valid_left);
    assign t_s = tbf_pkg::COORD_W'(cfg.valid_top);
    assign r_s = tbf_pkg::COORD_W'(cfg.valid_right);
    assign b_s = tbf_pkg::COORD_W'(cfg.valid_bottom);
    assign px_r = tbf_pkg::COORD_W'(row);
    assign px_c = tbf_pkg::COORD_W'(col);

    // a span narrower than its border stops the fill at twice the span
    assign h_lim = ((b_s - t_s) < (h_s - b_s)) ? (b_s + (b_s - t_s)) : h_s;
    assign w_lim = ((r_s - l_s) < (w_s - r_s)) ? (r_s + (r_s - l_s)) : w_s;

    // counter start values of the phase being entered
    always_comb
    begin
        phase_load = dp_cmd.setup ? tbf_pkg::PH_LEFT : tbf_pkg::phase_t'(phase_reg + 2'd1);
        o_init     = ZERO;
        i_init     = ZERO;
        case (phase_load)
            tbf_pkg::PH_LEFT:
            begin
                o_init = t_s;
                i_init = l_s - ONE;
            end
            tbf_pkg::PH_RIGHT:
            begin
                o_init = t_s;
                i_init = w_lim_reg - r_s - ONE;
            end
            default:
            begin
                o_init = ZERO;
                i_init = ZERO;
            end
        endcase
    end

    // loop bounds and copy coordinates of the current phase
    always_comb
    begin
        phase_skip = 1'b1;
        inner_last = 1'b1;
        outer_last = 1'b1;
        i_restart  = ZERO;
        dst_r      = o_reg;
        dst_c      = i_reg;
        src_r      = o_reg;
        src_c      = i_reg;
        case (phase_reg)
            tbf_pkg::PH_LEFT:
            begin
                phase_skip = !((l_s > ZERO) && (b_s > t_s));
                inner_last = (i_reg == ZERO);
                outer_last = (o_reg == b_s - ONE);
                i_restart  = l_s - ONE;
                dst_c      = l_s - ONE - i_reg;
                src_c      = l_s + OFS + i_reg;
            end
            tbf_pkg::PH_RIGHT:
            begin
                phase_skip = !((r_s < w_lim_reg) && (b_s > t_s));
                inner_last = (i_reg == ZERO);
                outer_last = (o_reg == b_s - ONE);
                i_restart  = w_lim_reg - r_s - ONE;
                dst_c      = r_s + i_reg;
                src_c      = r_s - ONE - OFS - i_reg;
            end
            tbf_pkg::PH_TOP:
            begin
                phase_skip = !((t_s > ZERO) && (w_lim_reg > ZERO));
                inner_last = (i_reg == w_lim_reg - ONE);
                outer_last = (o_reg == t_s - ONE);
                dst_r      = t_s - ONE - o_reg;
                src_r      = t_s + OFS + o_reg;
            end
            tbf_pkg::PH_BOTTOM:
            begin
                phase_skip = !((b_s < h_lim_reg) && (w_lim_reg > ZERO));
                inner_last = (i_reg == w_lim_reg - ONE);
                outer_last = (o_reg == h_lim_reg - b_s - ONE);
                dst_r      = b_s + o_reg;
                src_r      = b_s - ONE - OFS - o_reg;
            end
            default:
            begin
                phase_skip = 1'b1;
            end
        endcase
    end

    assign status.phase_skip = phase_skip;
    assign status.last_copy  = inner_last && outer_last;
    assign status.last_phase = (phase_reg == tbf_pkg::PH_BOTTOM);
    assign status.out_busy   = out_valid_reg && out_stall;

    // side columns count down, whole-row copies count up
    always_comb
    begin
        phase_next = phase_reg;
        o_next     = o_reg;
        i_next     = i_reg;
        if (dp_cmd.setup || dp_cmd.next_phase)
        begin
            phase_next = phase_load;
            o_next     = o_init;
            i_next     = i_init;
        end
        else if (dp_cmd.step)
        begin
            if (inner_last)
            begin
                o_next = o_reg + ONE;
                i_next = i_restart;
            end
            else if ((phase_reg == tbf_pkg::PH_LEFT) || (phase_reg == tbf_pkg::PH_RIGHT))
            begin
                i_next = i_reg - ONE;
            end
            else
            begin
                i_next = i_reg + ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tbf_pkg::PH_LEFT;
            o_reg     <= ZERO;
            i_reg     <= ZERO;
        end
        else
        begin
            phase_reg <= phase_next;
            o_reg     <= o_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.setup)
        begin
            w_lim_reg <= w_lim;
            h_lim_reg <= h_lim;
        end
    end

    // tile memory ports
    assign ram_we    = dp_cmd.px_wr || dp_cmd.fill_wr;
    assign ram_waddr = dp_cmd.px_wr ? tbf_pkg::flat_addr(px_r, px_c)
                                    : tbf_pkg::flat_addr(dst_r, dst_c);
    assign ram_wdata = dp_cmd.px_wr ? tbf_pkg::PIXEL_BITS'(pixel_in) : ram_rdata;
    assign ram_raddr = dp_cmd.px_rd ? tbf_pkg::flat_addr(px_r, px_c)
                                    : tbf_pkg::flat_addr(src_r, src_c);

    tbf_ram #(
        .WIDTH (tbf_pkg::PIXEL_BITS),
        .DEPTH (tbf_pkg::MEM_DEPTH)
    ) u_tile_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        pixel_out_next = pixel_out_reg;
        fill_done_next = fill_done_reg;
        if (dp_cmd.out_load)
        begin
            out_valid_next = 1'b1;
            pixel_out_next = dp_cmd.out_from_ram ? ram_rdata[7:0] : 8'd0;
            fill_done_next = dp_cmd.out_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg <= pixel_out_next;
        fill_done_reg <= fill_done_next;
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign fill_done = fill_done_reg;

endmodule

/* rtl/tile_reflect_border_fill_core.sv */
// top level of the tile reflect border fill block: register port, controller and datapath
// depends on tbf_pkg, tbf_ctrl, tbf_datapath (which holds the tbf_ram tile memory)

// A 64 x 64 tile of 8-bit pixels at flat address row * 64 + col, with a reflect-101 border
// fill. Each item carries one command: write a pixel, read a pixel, run the fill, or the
// unused code, which does nothing; every item gives exactly one result (pixel_out holds
// the read pixel and is zero otherwise, fill_done is set only for a fill). Sequence: a write
// or an unused command leaves the block idle, and the next item may follow at once; a read
// passes through a wait state, since the tile memory's read data is registered. A fill
// runs through the accepting cycle, a setup state, a check state per border side (left,
// right, top, bottom), then one memory read and one memory write per copied pixel
// through the memory's single write port and single read port. The block takes no
// new item while a fill runs, and no item while an unconsumed result is stalled at the
// output; it does take one in the cycle the waiting result leaves. Tile contents are not
// cleared at reset, so no clearing pass is needed, and reading a never-written pixel gives
// an unspecified value. Configuration registers sit at byte addresses 4*i and may be
// written only while the block is idle.
module tile_reflect_border_fill_core (
    input  logic                            clk,
    input  logic                            rst_n,

    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [tbf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [tbf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,

    // item input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [5:0]                      col,
    input  logic [5:0]                      row,
    input  logic [7:0]                      pixel_in,

    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      pixel_out,
    output logic                            fill_done
);

    tbf_pkg::cfg_regs_t  cfg_reg;
    tbf_pkg::cfg_regs_t  cfg_next;
    tbf_pkg::reg_idx_t   reg_idx;
    logic                cfg_wr;
    tbf_pkg::dp_cmd_t    dp_cmd;
    tbf_pkg::dp_status_t dp_status;

    // ------------------------------------------------------------------
    // register port: no wait states, word-aligned registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = tbf_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                tbf_pkg::REG_BLOCK_WIDTH:  cfg_next.block_width  = pwdata[6:0];
                tbf_pkg::REG_BLOCK_HEIGHT: cfg_next.block_height = pwdata[6:0];
                tbf_pkg::REG_VALID_LEFT:   cfg_next.valid_left   = pwdata[5:0];
                tbf_pkg::REG_VALID_TOP:    cfg_next.valid_top    = pwdata[5:0];
                tbf_pkg::REG_VALID_RIGHT:  cfg_next.valid_right  = pwdata[6:0];
                tbf_pkg::REG_VALID_BOTTOM: cfg_next.valid_bottom = pwdata[6:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // reset values describe a full 64 x 64 valid tile
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_width  <= 7'd64;
            cfg_reg.block_height <= 7'd64;
            cfg_reg.valid_left   <= 6'd0;
            cfg_reg.valid_top    <= 6'd0;
            cfg_reg.valid_right  <= 7'd64;
            cfg_reg.valid_bottom <= 7'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back, unused addresses read zero
    always_comb
    begin
        case (reg_idx)
            tbf_pkg::REG_BLOCK_WIDTH:  prdata = tbf_pkg::CFG_DATA_W'(cfg_reg.block_width);
            tbf_pkg::REG_BLOCK_HEIGHT: prdata = tbf_pkg::CFG_DATA_W'(cfg_reg.block_height);
            tbf_pkg::REG_VALID_LEFT:   prdata = tbf_pkg::CFG_DATA_W'(cfg_reg.valid_left);
            tbf_pkg::REG_VALID_TOP:    prdata = tbf_pkg::CFG_DATA_W'(cfg_reg.valid_top);
            tbf_pkg::REG_VALID_RIGHT:  prdata = tbf_pkg::CFG_DATA_W'(cfg_reg.valid_right);
            tbf_pkg::REG_VALID_BOTTOM: prdata = tbf_pkg::CFG_DATA_W'(cfg_reg.valid_bottom);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // controller: accepts items, sequences the fill phases
    // ------------------------------------------------------------------
    tbf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .item_cmd (cmd),
        .status   (dp_status),
        .in_stall (in_stall),
        .dp_cmd   (dp_cmd)
    );

    // ------------------------------------------------------------------
    // datapath: tile memory, loop counters, result register
    // ------------------------------------------------------------------
    tbf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .dp_cmd    (dp_cmd),
        .col       (col),
        .row       (row),
        .pixel_in  (pixel_in),
        .out_stall (out_stall),
        .status    (dp_status),
        .out_valid (out_valid),
        .pixel_out (pixel_out),
        .fill_done (fill_done)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // an item is only taken when the result register is free or draining
    a_accept_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (!out_valid || !out_stall))
        else $error("item accepted while a stalled result is held");

    // a new result never overwrites one that is still waiting
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result register loaded while holding a stalled result");

    // every fill write uses data read in the cycle before
    a_fill_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.fill_wr |-> $past(dp_cmd.fill_rd))
        else $error("fill write without a preceding source read");

    // a fill holds off the input in the following cycle
    a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (cmd == tbf_pkg::CMD_FILL)) |=> in_stall)
        else $error("input not stalled after a fill command");

endmodule

/* tb/tbf_checker.sv */
`timescale 1ns / 1ps
// result checker for the tile reflect border fill block: keeps its own tile copy and registers,
// predicts every result from the accepted items and compares them in order
// depends on tbf_pkg for commands, register indexes and tile sizes
module tbf_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [tbf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [tbf_pkg::CFG_DATA_W-1:0]  pwdata,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [5:0]                      col,
    input  logic [5:0]                      row,
    input  logic [7:0]                      pixel_in,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [7:0]                      pixel_out,
    input  logic                            fill_done,
    output int                              errors,
    output int                              pending,
    output int                              results,
    output int                              reads,
    output int                              fills
);

    typedef struct packed {
        logic [7:0] pixel;
        logic       done;
    } tile_result_t;

    logic [7:0]   tile_px [tbf_pkg::MEM_DEPTH];
    logic [6:0]   blk_w;
    logic [6:0]   blk_h;
    logic [5:0]   vis_l;
    logic [5:0]   vis_t;
    logic [6:0]   vis_r;
    logic [6:0]   vis_b;
    tile_result_t result_q [$];
    int           n_err;
    int           n_res;
    int           n_read;
    int           n_fill;

    // flat pixel address, wrapping over the whole tile memory
    function automatic int px_index(int r, int c);
        return (r * tbf_pkg::TILE_MAX_WIDTH + c) & (tbf_pkg::MEM_DEPTH - 1);
    endfunction

    function automatic void copy_px(int dr, int dc, int sr, int sc);
        tile_px[px_index(dr, dc)] = tile_px[px_index(sr, sc)];
    endfunction

    // reflect-101 padding: side columns of valid rows first, then whole rows
    function automatic void mirror_borders();
        int w;
        int h;
        int l;
        int t;
        int r;
        int b;
        w = int'(blk_w);
        h = int'(blk_h);
        l = int'(vis_l);
        t = int'(vis_t);
        r = int'(vis_r);
        b = int'(vis_b);
        // a span narrower than the far border limits the fill to twice the span
        if (b - t < h - b)
            h = b + (b - t);
        if (r - l < w - r)
            w = r + (r - l);
        if (l > 0)
            for (int y = t; y < b; y++)
                for (int x = l - 1; x >= 0; x--)
                    copy_px(y, l - 1 - x, y, l + tbf_pkg::OFFSET + x);
        if (r < w)
            for (int y = t; y < b; y++)
                for (int x = w - r - 1; x >= 0; x--)
                    copy_px(y, r + x, y, r - 1 - tbf_pkg::OFFSET - x);
        if (t > 0)
            for (int x = 0; x < t; x++)
                for (int j = 0; j < w; j++)
                    copy_px(t - 1 - x, j, t + tbf_pkg::OFFSET + x, j);
        if (b < h)
            for (int x = 0; x < h - b; x++)
                for (int j = 0; j < w; j++)
                    copy_px(b + x, j, b - 1 - tbf_pkg::OFFSET - x, j);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tile_result_t want;
        if (!rst_n)
        begin
            blk_w  = 7'd64;
            blk_h  = 7'd64;
            vis_l  = 6'd0;
            vis_t  = 6'd0;
            vis_r  = 7'd64;
            vis_b  = 7'd64;
            result_q.delete();
            n_err  = 0;
            n_res  = 0;
            n_read = 0;
            n_fill = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                case (tbf_pkg::reg_idx_t'(paddr[tbf_pkg::CFG_ADDR_W-1:2]))
                    tbf_pkg::REG_BLOCK_WIDTH:  blk_w = pwdata[6:0];
                    tbf_pkg::REG_BLOCK_HEIGHT: blk_h = pwdata[6:0];
                    tbf_pkg::REG_VALID_LEFT:   vis_l = pwdata[5:0];
                    tbf_pkg::REG_VALID_TOP:    vis_t = pwdata[5:0];
                    tbf_pkg::REG_VALID_RIGHT:  vis_r = pwdata[6:0];
                    tbf_pkg::REG_VALID_BOTTOM: vis_b = pwdata[6:0];
                    default: ;
                endcase

            // results first, so a result never meets an item accepted at the same edge
            if (out_valid && !out_stall)
            begin
                n_res++;
                if (result_q.size() == 0)
                begin
                    $error("result with no item waiting: pixel_out %0d fill_done %0d",
                           pixel_out, fill_done);
                    n_err++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (pixel_out !== want.pixel)
                    begin
                        $error("pixel_out mismatch: expected %0d, got %0d",
                               want.pixel, pixel_out);
                        n_err++;
                    end
                    if (fill_done !== want.done)
                    begin
                        $error("fill_done mismatch: expected %0d, got %0d",
                               want.done, fill_done);
                        n_err++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                want = '0;
                case (tbf_pkg::cmd_t'(cmd))
                    tbf_pkg::CMD_WRITE: tile_px[px_index(row, col)] = pixel_in;
                    tbf_pkg::CMD_FILL:
                    begin
                        mirror_borders();
                        want.done = 1'b1;
                        n_fill++;
                    end
                    tbf_pkg::CMD_READ:
                    begin
                        want.pixel = tile_px[px_index(row, col)];
                        n_read++;
                    end
                    default: ;
                endcase
                result_q.push_back(want);
            end
        end
        errors  <= n_err;
        pending <= result_q.size();
        results <= n_res;
        reads   <= n_read;
        fills   <= n_fill;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// testbench top for the tile reflect border fill block: clock, reset, register writes,
// item stimulus and verdict; depends on tbf_pkg, tile_reflect_border_fill_core, tbf_checker
module tb;

    // random part: three pacing modes, several tile settings each
    localparam int PACE_MODES    = 3;
    localparam int CFG_PER_MODE  = 6;
    localparam int ITEMS_PER_CFG = 52;

    // seed block for the preload: its mirror fill covers the whole tile
    localparam int SEED_LO = 21;
    localparam int SEED_HI = 43;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tbf_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [tbf_pkg::CFG_DATA_W-1:0]  pwdata;
    logic [tbf_pkg::CFG_DATA_W-1:0]  prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_stall;
    logic [1:0]                      cmd;
    logic [5:0]                      col;
    logic [5:0]                      row;
    logic [7:0]                      pixel_in;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [7:0]                      pixel_out;
    logic                            fill_done;

    int send_idle;
    int recv_idle;
    int errors;
    int pending;
    int results;
    int reads;
    int fills;
    int cfg_count;
    // current tile extent, used to aim half the addresses at the padded area
    int tile_w;
    int tile_h;

    tile_reflect_border_fill_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .col       (col),
        .row       (row),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .fill_done (fill_done)
    );

    // checker sits beside the block and sees exactly what the block sees
    tbf_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .col       (col),
        .row       (row),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .fill_done (fill_done),
        .errors    (errors),
        .pending   (pending),
        .results   (results),
        .reads     (reads),
        .fills     (fills)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side back-pressure, redrawn every cycle
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // hard stop far beyond the slowest legal run (worst fills included)
    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // drop valid, then hold until every predicted result has left the block;
    // ends at a falling edge
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        @(negedge clk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic reg_write(input tbf_pkg::reg_idx_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tbf_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // new tile geometry, written only once the block has gone idle
    task automatic set_geometry(input int w, input int h, input int l, input int t,
                                input int r, input int b);
        wait_drained();
        reg_write(tbf_pkg::REG_BLOCK_WIDTH, w);
        reg_write(tbf_pkg::REG_BLOCK_HEIGHT, h);
        reg_write(tbf_pkg::REG_VALID_LEFT, l);
        reg_write(tbf_pkg::REG_VALID_TOP, t);
        reg_write(tbf_pkg::REG_VALID_RIGHT, r);
        reg_write(tbf_pkg::REG_VALID_BOTTOM, b);
        tile_w = w;
        tile_h = h;
        cfg_count++;
    endtask

    // one item with random leading gaps; returns at the falling edge after acceptance
    task automatic send_item(input tbf_pkg::cmd_t c, input int cc, input int rr,
                             input int px);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        col      <= 6'(cc);
        row      <= 6'(rr);
        pixel_in <= 8'(px);
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        int k;
        int rr;
        int cc;
        int lim_r;
        int lim_c;
        int w;
        int h;
        int l;
        int t;
        int r;
        int b;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        cmd       = tbf_pkg::CMD_WRITE;
        col       = '0;
        row       = '0;
        pixel_in  = '0;
        send_idle = 11;
        recv_idle = 61;
        cfg_count = 0;
        tile_w    = 64;
        tile_h    = 64;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // tile memory powers up undefined: load a centered seed block and mirror it
        // out to every pixel, so no read and no fill source touches an unwritten entry
        set_geometry(64, 64, SEED_LO, SEED_LO, SEED_HI, SEED_HI);
        for (int y = SEED_LO; y < SEED_HI; y++)
            for (int x = SEED_LO; x < SEED_HI; x++)
                send_item(tbf_pkg::CMD_WRITE, x, y, $urandom_range(255));
        send_item(tbf_pkg::CMD_FILL, 0, 0, 0);
        set_geometry(64, 64, 0, 0, 64, 64);

        // corner pixels with extreme values, read back
        send_item(tbf_pkg::CMD_WRITE, 0, 0, 8'h00);
        send_item(tbf_pkg::CMD_WRITE, 63, 63, 8'hff);
        send_item(tbf_pkg::CMD_WRITE, 63, 0, 8'h55);
        send_item(tbf_pkg::CMD_WRITE, 0, 63, 8'haa);
        send_item(tbf_pkg::CMD_READ, 0, 0, 8'hff);
        send_item(tbf_pkg::CMD_READ, 63, 63, 8'h00);
        send_item(tbf_pkg::CMD_READ, 63, 0, 8'h00);
        send_item(tbf_pkg::CMD_READ, 0, 63, 8'h00);
        // unused command code, all-ones and all-zero fields
        send_item(tbf_pkg::CMD_NOP, 63, 63, 8'hff);
        send_item(tbf_pkg::CMD_NOP, 0, 0, 8'h00);
        // reset geometry: every border empty, fill copies nothing
        send_item(tbf_pkg::CMD_FILL, 0, 0, 0);

        // ordinary rectangle with borders on all four sides
        set_geometry(64, 64, 8, 8, 56, 56);
        send_item(tbf_pkg::CMD_FILL, 0, 0, 0);
        send_item(tbf_pkg::CMD_READ, 3, 60, 0);
        send_item(tbf_pkg::CMD_READ, 60, 60, 0);

        // one-wide span: left and top sources step just past the span
        set_geometry(64, 64, 20, 30, 21, 31);
        send_item(tbf_pkg::CMD_FILL, 0, 0, 0);
        send_item(tbf_pkg::CMD_READ, 22, 30, 0);
        send_item(tbf_pkg::CMD_READ, 20, 28, 0);

        // width past a tile row: row copies spill into the following rows
        set_geometry(100, 64, 10, 4, 90, 60);
        send_item(tbf_pkg::CMD_FILL, 0, 0, 0);
        send_item(tbf_pkg::CMD_READ, 40, 2, 0);

        // inverted rectangle: nothing to fill
        set_geometry(64, 64, 40, 50, 10, 5);
        send_item(tbf_pkg::CMD_FILL, 0, 0, 0);

        // every register at its top value, sources wrap round the memory
        set_geometry(127, 127, 63, 63, 127, 127);
        send_item(tbf_pkg::CMD_FILL, 0, 0, 0);
        send_item(tbf_pkg::CMD_READ, 0, 0, 0);

        // every register at zero
        set_geometry(0, 0, 0, 0, 0, 0);
        send_item(tbf_pkg::CMD_FILL, 0, 0, 0);

        for (int m = 0; m < PACE_MODES; m++)
        begin
            case (m)
                0:
                begin
                    send_idle = 11;
                    recv_idle = 61;
                end
                1:
                begin
                    send_idle = 61;
                    recv_idle = 11;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int s = 0; s < CFG_PER_MODE; s++)
            begin
                if ($urandom_range(5) == 0)
                begin
                    // raw register values over their full width, legal or not
                    set_geometry($urandom_range(127), $urandom_range(127), $urandom_range(63),
                                 $urandom_range(63), $urandom_range(127), $urandom_range(127));
                end
                else
                begin
                    // well-formed: valid rectangle inside the padded tile
                    w = $urandom_range(64, 1);
                    h = $urandom_range(64, 1);
                    l = $urandom_range(w - 1);
                    t = $urandom_range(h - 1);
                    r = $urandom_range(w, l + 1);
                    b = $urandom_range(h, t + 1);
                    set_geometry(w, h, l, t, r, b);
                end
                lim_c = (tile_w > 64) ? 63 : ((tile_w == 0) ? 0 : tile_w - 1);
                lim_r = (tile_h > 64) ? 63 : ((tile_h == 0) ? 0 : tile_h - 1);
                for (int i = 0; i < ITEMS_PER_CFG; i++)
                begin
                    // half the addresses inside the padded tile, where fills land
                    if ($urandom_range(1))
                    begin
                        cc = $urandom_range(63);
                        rr = $urandom_range(63);
                    end
                    else
                    begin
                        cc = $urandom_range(lim_c);
                        rr = $urandom_range(lim_r);
                    end
                    k = $urandom_range(99);
                    if (k < 44)
                        send_item(tbf_pkg::CMD_WRITE, cc, rr, $urandom_range(255));
                    else if (k < 90)
                        send_item(tbf_pkg::CMD_READ, cc, rr, $urandom_range(255));
                    else if (k < 95)
                        send_item(tbf_pkg::CMD_FILL, cc, rr, $urandom_range(255));
                    else
                        send_item(tbf_pkg::CMD_NOP, cc, rr, $urandom_range(255));
                end
            end
        end

        wait_drained();
        // let any stray result show up before the verdict
        repeat (20) @(posedge clk);

        $display("checked %0d results: %0d pixel reads, %0d border fills", results, reads, fills);
        $display("over %0d tile settings and three handshake pacing modes", cfg_count);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
